/* src/m3inv_pkg.sv */
package m3inv_pkg;

  localparam int MAT_DIM = 3;
  localparam int MAT_ENTRIES = MAT_DIM * MAT_DIM;

endpackage

/* src/m3inv_cof.sv */
module m3inv_cof
  import m3inv_pkg::*;
#(
  parameter int W = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic signed [W-1:0] m [MAT_ENTRIES],
  output logic                out_valid,
  output logic [3*W+2:0]      dmag,
  output logic                dneg,
  output logic                dzero,
  output logic [2*W:0]        cmag [MAT_ENTRIES],
  output logic                cneg [MAT_ENTRIES]
);

  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int LW = W + 1;
  localparam int DW = 3 * W + 1;
  localparam int MW = 3 * W + 3;

  logic [5:0] vld;

  logic signed [PW-1:0]   pa [MAT_ENTRIES];
  logic signed [PW-1:0]   pb [MAT_ENTRIES];
  logic signed [CW-1:0]   cof2 [MAT_ENTRIES];
  logic signed [CW-1:0]   cof3 [MAT_ENTRIES];
  logic signed [CW-1:0]   cof4 [MAT_ENTRIES];
  logic signed [CW-1:0]   cof5 [MAT_ENTRIES];
  logic signed [W-1:0]    e1 [MAT_DIM];
  logic signed [W-1:0]    e2 [MAT_DIM];
  logic signed [PW-1:0]   ph [MAT_DIM];
  logic signed [PW+1:0]   pl [MAT_DIM];
  logic signed [DW-1:0]   t4 [MAT_DIM];
  logic signed [MW-1:0]   det5;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  assign out_valid = vld[5];

  for (genvar gi = 0; gi < MAT_DIM; gi++) begin : g_row
    for (genvar gj = 0; gj < MAT_DIM; gj++) begin : g_col
      localparam int I1 = (gi + 1) % MAT_DIM;
      localparam int I2 = (gi + 2) % MAT_DIM;
      localparam int J1 = (gj + 1) % MAT_DIM;
      localparam int J2 = (gj + 2) % MAT_DIM;
      localparam int K = gi * MAT_DIM + gj;

      always_ff @(posedge clk) begin
        if (en) begin
          pa[K]   <= m[I1*MAT_DIM+J1] * m[I2*MAT_DIM+J2];
          pb[K]   <= m[I1*MAT_DIM+J2] * m[I2*MAT_DIM+J1];
          cof2[K] <= {pa[K][PW-1], pa[K]} - {pb[K][PW-1], pb[K]};
          cof3[K] <= cof2[K];
          cof4[K] <= cof3[K];
          cof5[K] <= cof4[K];
          cneg[K] <= cof5[K][CW-1];
          cmag[K] <= cof5[K][CW-1] ? CW'(-cof5[K]) : CW'(cof5[K]);
        end
      end
    end
  end

  for (genvar gj = 0; gj < MAT_DIM; gj++) begin : g_det
    always_ff @(posedge clk) begin
      if (en) begin
        e1[gj] <= m[gj];
        e2[gj] <= e1[gj];
        ph[gj] <= e2[gj] * $signed(cof2[gj][CW-1:LW]);
        pl[gj] <= e2[gj] * $signed({1'b0, cof2[gj][LW-1:0]});
        t4[gj] <= (DW'(ph[gj]) <<< LW) + DW'(pl[gj]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det5  <= MW'(t4[0]) + MW'(t4[1]) + MW'(t4[2]);
      dneg  <= det5[MW-1];
      dzero <= (det5 == '0);
      dmag  <= det5[MW-1] ? MW'(-det5) : MW'(det5);
    end
  end

endmodule

/* src/m3inv_div.sv */
module m3inv_div #(
  parameter int W = 24,
  parameter int F = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            in_valid,
  input  logic [2*W:0]    cmag,
  input  logic [3*W+2:0]  dmag,
  input  logic            neg,
  output logic            out_valid,
  output logic [W-1:0]    quo_out,
  output logic            ovf_out,
  output logic            neg_out
);

  localparam int NW = 2 * W + 1 + 2 * F;
  localparam int MW = 3 * W + 3;
  localparam int RW = (NW > MW + W) ? NW : MW + W;

  logic [RW-1:0] rem [W+1];
  logic [W-1:0]  quo [W+1];
  logic [MW-1:0] dm  [W+1];
  logic          ovf [W+1];
  logic          ng  [W+1];
  logic [W:0]    vl;

  logic [RW-1:0] num_ext;

  assign num_ext = RW'(cmag) << (2 * F);

  always_ff @(posedge clk) begin
    if (rst) begin
      vl[0] <= 1'b0;
    end else if (en) begin
      vl[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= num_ext;
      quo[0] <= '0;
      dm[0]  <= dmag;
      ng[0]  <= neg;
      ovf[0] <= num_ext >= (RW'(dmag) << W);
    end
  end

  for (genvar gk = 1; gk <= W; gk++) begin : g_step
    localparam int B = W - gk;
    logic [RW-1:0] sh;
    logic          take;

    assign sh   = RW'(dm[gk-1]) << B;
    assign take = rem[gk-1] >= sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[gk] <= 1'b0;
      end else if (en) begin
        vl[gk] <= vl[gk-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[gk]    <= take ? rem[gk-1] - sh : rem[gk-1];
        quo[gk]    <= quo[gk-1] | (W'(take) << B);
        dm[gk]     <= dm[gk-1];
        ovf[gk]    <= ovf[gk-1];
        ng[gk]     <= ng[gk-1];
      end
    end
  end

  assign out_valid = vl[W];
  assign quo_out   = quo[W];
  assign ovf_out   = ovf[W];
  assign neg_out   = ng[W];

endmodule

/* src/matrix3_inverse_adjugate_unit.sv */
// 3x3 matrix inverse by the adjugate. One matrix request per cycle on the
// slave side, one result per request on the master side, in order. Entries
// are signed fixed point (ENTRY_WIDTH bits, FRACTION_BITS fraction bits).
// Six stages form the cofactors and the exact determinant, then each of
// nine dividers resolves one quotient bit per stage after a range check
// stage, and an output register follows. Throughput is one
// matrix per cycle; a full skid register stalls the whole pipeline. Inverse
// entries and the determinant are truncated toward zero and saturated; a
// zero determinant raises tuser and forces all data fields to zero.
module matrix3_inverse_adjugate_unit
  import m3inv_pkg::*;
#(
  parameter int ENTRY_WIDTH = 24,
  parameter int FRACTION_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  input  logic [((MAT_ENTRIES*ENTRY_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // r00, r01, r02, r10, r11, r12, r20, r21, r22, determinant
  output logic [(((MAT_ENTRIES+1)*ENTRY_WIDTH+7)/8)*8-1:0] m_tdata,
  // singular
  output logic m_tuser
);

  localparam int W = ENTRY_WIDTH;
  localparam int F = FRACTION_BITS;
  localparam int MW = 3 * W + 3;
  localparam int CW = 2 * W + 1;
  localparam int RBITS = MAT_ENTRIES * W;
  localparam int OUT_TDW = (((MAT_ENTRIES + 1) * W + 7) / 8) * 8;

  logic en;
  logic skid_full;
  logic [OUT_TDW-1:0] skid_d;
  logic skid_u;

  logic signed [W-1:0] m_in [MAT_ENTRIES];
  logic cv;
  logic [MW-1:0] dmag;
  logic dneg;
  logic dzero;
  logic [CW-1:0] cmag [MAT_ENTRIES];
  logic cneg [MAT_ENTRIES];

  logic [W-1:0] quo [MAT_ENTRIES];
  logic ovf [MAT_ENTRIES];
  logic qneg [MAT_ENTRIES];
  logic [MAT_ENTRIES-1:0] dv;

  logic [W-1:0] dl [W+1];
  logic sl [W+1];

  logic [MW-1:0] dsh;
  logic [MW-1:0] dlim;
  logic [MW-1:0] dsat;
  logic [W-1:0]  dval;

  logic [RBITS-1:0] rres;
  logic [OUT_TDW-1:0] pd;
  logic pv;

  assign en = !skid_full;
  assign s_tready = en;

  for (genvar gk = 0; gk < MAT_ENTRIES; gk++) begin : g_in
    assign m_in[gk] = s_tdata[gk*W +: W];
  end

  m3inv_cof #(.W(W)) u_cof (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .m         (m_in),
    .out_valid (cv),
    .dmag      (dmag),
    .dneg      (dneg),
    .dzero     (dzero),
    .cmag      (cmag),
    .cneg      (cneg)
  );

  for (genvar gk = 0; gk < MAT_ENTRIES; gk++) begin : g_div
    m3inv_div #(.W(W), .F(F)) u_div (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (cv),
      .cmag      (cmag[gk]),
      .dmag      (dmag),
      .neg       (cneg[gk] ^ dneg),
      .out_valid (dv[gk]),
      .quo_out   (quo[gk]),
      .ovf_out   (ovf[gk]),
      .neg_out   (qneg[gk])
    );
  end

  assign dsh  = dmag >> (2 * F);
  assign dlim = (MW'(1) << (W - 1)) - MW'(!dneg);
  assign dsat = (dsh > dlim) ? dlim : dsh;
  assign dval = dneg ? W'(-dsat[W-1:0]) : dsat[W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      dl[0] <= dval;
      sl[0] <= dzero;
    end
  end

  for (genvar gk = 1; gk <= W; gk++) begin : g_dline
    always_ff @(posedge clk) begin
      if (en) begin
        dl[gk] <= dl[gk-1];
        sl[gk] <= sl[gk-1];
      end
    end
  end

  for (genvar gi = 0; gi < MAT_DIM; gi++) begin : g_orow
    for (genvar gj = 0; gj < MAT_DIM; gj++) begin : g_ocol
      localparam int K = gi * MAT_DIM + gj;
      localparam int O = gj * MAT_DIM + gi;
      logic [W-1:0] lim;
      logic [W-1:0] qv;

      assign lim = qneg[K] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      assign qv  = (ovf[K] || quo[K] > lim) ? lim : quo[K];
      assign rres[O*W +: W] = sl[W] ? '0 : (qneg[K] ? W'(-qv) : qv);
    end
  end

  assign pv = dv[0];
  assign pd = OUT_TDW'({dl[W], rres});

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid  <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (m_tready) begin
        skid_full <= 1'b0;
      end
    end else if (pv) begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= 1'b1;
      end else begin
        skid_full <= 1'b1;
      end
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (m_tready) begin
        m_tdata <= skid_d;
        m_tuser <= skid_u;
      end
    end else if (pv) begin
      if (!m_tvalid || m_tready) begin
        m_tdata <= pd;
        m_tuser <= sl[W];
      end else begin
        skid_d <= pd;
        skid_u <= sl[W];
      end
    end
  end

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[RBITS-1:0] == '0)
    else $error("singular result carries nonzero inverse");

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> m_tvalid)
    else $error("skid holds a request while output is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    pv && m_tvalid && !m_tready && !skid_full |=> skid_full)
    else $error("pipeline result dropped on output stall");

  a_div_lockstep: assert property (@(posedge clk) disable iff (rst)
    dv == '0 || dv == '1)
    else $error("dividers out of step");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
  import m3inv_pkg::*;

  localparam int EW = 24;
  localparam int FB = 16;
  localparam int IN_W = ((MAT_ENTRIES * EW + 7) / 8) * 8;
  localparam int OUT_W = (((MAT_ENTRIES + 1) * EW + 7) / 8) * 8;
  localparam int STALL_LIMIT = 20000;

  typedef logic signed [EW-1:0] entry_t;
  typedef entry_t matrix_t [MAT_ENTRIES];
  typedef struct {
    entry_t inv [MAT_ENTRIES];
    entry_t det;
    logic   singular;
  } inverse_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_W-1:0] m_tdata;
  logic m_tuser;

  inverse_t pending_inverses [$];
  int errors = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit idle_on = 1'b1;

  matrix3_inverse_adjugate_unit #(.ENTRY_WIDTH(EW), .FRACTION_BITS(FB)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic entry_t saturate_entry(input logic [127:0] mag, input bit neg);
    logic [127:0] limit;
    limit = neg ? (128'd1 << (EW - 1)) : (128'd1 << (EW - 1)) - 1;
    if (mag > limit) mag = limit;
    return neg ? entry_t'(-mag[EW-1:0]) : entry_t'(mag[EW-1:0]);
  endfunction

  function automatic inverse_t invert_matrix(input matrix_t m);
    logic signed [127:0] a [3][3];
    logic signed [127:0] cof [3][3];
    logic signed [127:0] d;
    logic [127:0] dmag, cmag;
    inverse_t res;
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        a[i][j] = 128'(m[i*3+j]);
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        cof[i][j] = a[(i+1)%3][(j+1)%3] * a[(i+2)%3][(j+2)%3]
                  - a[(i+1)%3][(j+2)%3] * a[(i+2)%3][(j+1)%3];
    d = a[0][0] * cof[0][0] + a[0][1] * cof[0][1] + a[0][2] * cof[0][2];
    res.singular = (d == 0);
    res.det = '0;
    for (int k = 0; k < MAT_ENTRIES; k++) res.inv[k] = '0;
    if (d != 0) begin
      dmag = (d < 0) ? -d : d;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          cmag = (cof[i][j] < 0) ? -cof[i][j] : cof[i][j];
          res.inv[j*3+i] = saturate_entry((cmag << (2 * FB)) / dmag,
                                          (cof[i][j] < 0) != (d < 0));
        end
      res.det = saturate_entry(dmag >> (2 * FB), d < 0);
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [EW-1:0] got,
                                 input logic [EW-1:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic send_matrix(input matrix_t m);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    for (int k = 0; k < MAT_ENTRIES; k++) s_tdata[k*EW +: EW] <= m[k];
    do @(posedge clk); while (!s_tready);
    pending_inverses.push_back(invert_matrix(m));
  endtask

  task automatic wait_drained;
    s_tvalid <= 1'b0;
    while (pending_inverses.size() != 0) @(posedge clk);
  endtask

  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    kind = $urandom_range(0, 5);
    for (int k = 0; k < MAT_ENTRIES; k++) begin
      case (kind)
        0, 1: m[k] = entry_t'($urandom);
        2: m[k] = entry_t'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        3: m[k] = entry_t'($signed($urandom_range(0, 1 << 15)) - (1 << 14));
        default: m[k] = (k % 4 == 0) ? entry_t'($urandom)
                        : entry_t'($signed($urandom_range(0, 1 << 12)) - (1 << 11));
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      for (int c = 0; c < 3; c++) m[6+c] = m[$urandom_range(0, 1)*3+c];
    end else if ($urandom_range(0, 19) == 0) begin
      for (int r = 0; r < 3; r++) m[r*3+1] = '0;
    end
    return m;
  endfunction

  task automatic test_directed;
    matrix_t m;
    entry_t vals [6];
    vals = '{24'sh010000, 24'sh7FFFFF, -24'sh800000, 24'sh000001, -24'sh000001, 24'sh0};
    foreach (vals[v]) begin
      for (int k = 0; k < MAT_ENTRIES; k++) m[k] = (k % 4 == 0) ? vals[v] : '0;
      send_matrix(m);
    end
    for (int k = 0; k < MAT_ENTRIES; k++) m[k] = 24'sh7FFFFF;
    send_matrix(m);
    for (int k = 0; k < MAT_ENTRIES; k++) m[k] = -24'sh800000;
    send_matrix(m);
    for (int k = 0; k < MAT_ENTRIES; k++) m[k] = (k % 2) ? 24'sh7FFFFF : -24'sh800000;
    send_matrix(m);
    m = '{24'sh020000, 24'sh010000, 0, 24'sh010000, 24'sh030000, 24'sh010000,
          0, 24'sh010000, 24'sh040000};
    send_matrix(m);
    m = '{0, 24'sh010000, 0, 24'sh010000, 0, 0, 0, 0, -24'sh010000};
    send_matrix(m);
    m = '{24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF, -24'sh800000, 24'sh7FFFFF,
          -24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF, -24'sh800000};
    send_matrix(m);
    m = '{24'sh000100, 0, 0, 0, 24'sh000100, 0, 0, 0, -24'sh000100};
    send_matrix(m);
    m = '{24'sh100000, 24'sh000001, 0, 0, 24'sh100000, 0, 0, 0, 24'sh100000};
    send_matrix(m);
    for (int k = 0; k < MAT_ENTRIES; k++) m[k] = entry_t'(k + 1) <<< 16;
    send_matrix(m);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    for (int n = 0; n < count; n++) send_matrix(random_matrix());
  endtask

  task automatic test_backpressure;
    hold_cycles = 300;
    for (int n = 0; n < 60; n++) send_matrix(random_matrix());
    wait_drained();
    repeat (5) @(posedge clk);
  endtask

  task automatic test_streaming;
    idle_on = 1'b0;
    test_random(100);
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(500);
    wait_drained();
    test_backpressure();
    test_random(480);
    test_streaming();
    repeat (40) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    int burst;
    burst = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        if (idle_on && burst == 0 && $urandom_range(0, 7) == 0)
          burst = $urandom_range(1, 13);
        if (burst > 0) begin
          m_tready <= 1'b0;
          burst--;
        end else begin
          m_tready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    inverse_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_inverses.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[EW-1:0], '0);
      end else begin
        want = pending_inverses.pop_front();
        for (int k = 0; k < MAT_ENTRIES; k++)
          if (m_tdata[k*EW +: EW] !== want.inv[k])
            report_mismatch($sformatf("r%0d%0d", k / 3, k % 3), m_tdata[k*EW +: EW],
                            want.inv[k]);
        if (m_tdata[MAT_ENTRIES*EW +: EW] !== want.det)
          report_mismatch("determinant", m_tdata[MAT_ENTRIES*EW +: EW], want.det);
        if (m_tuser !== want.singular)
          report_mismatch("singular", EW'(m_tuser), EW'(want.singular));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
